FILE: src/tvls_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the quarter-wave sine function of the tone generator.
package tvls_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INC,
    ST_SINE,
    ST_MUL,
    ST_ACC,
    ST_ABS,
    ST_SCALE,
    ST_ROUND
  } state_t;

  typedef struct packed {
    logic       in_ready;
    logic       inc_step;
    logic       inc_lo_cap;
    logic       inc_hi_cap;
    logic       sine_step;
    logic       mul_step;
    logic       acc_en;
    logic       abs_en;
    logic       scale_en;
    logic       round_en;
    logic [2:0] idx;
  } ctl_t;

  localparam logic [1:0] REG_ENABLE    = 2'd0;
  localparam logic [1:0] REG_TONE_STEP = 2'd1;
  localparam logic [1:0] REG_LFO_STEP  = 2'd2;

  localparam logic [31:0] TONE_STEP_RESET = 32'd16800042;
  localparam logic [31:0] LFO_STEP_RESET  = 32'd48696;

  localparam logic [16:0] LFO1_MULT = 17'd68157;
  localparam logic [16:0] LFO2_MULT = 17'd71434;
  localparam logic [14:0] MIX_MULT  = 15'd19661;

  localparam logic [2:0] INC_LAST  = 3'd1;
  localparam logic [2:0] SINE_LAST = 3'd5;
  localparam logic [2:0] MUL_LAST  = 3'd2;

  function automatic logic [63:0] quarter_sine(input int unsigned x,
                                               input int unsigned qbits,
                                               input int unsigned sbits);
    logic [63:0] u;
    logic [63:0] u2;
    logic [63:0] t;
    logic [63:0] r;
    logic [63:0] amp;
    logic [63:0] full;
    u    = 64'(x) << (30 - qbits);
    u2   = (u * u) >> 30;
    t    = 64'd172272;
    t    = 64'd5026900 - ((u2 * t) >> 30);
    t    = 64'd85568169 - ((u2 * t) >> 30);
    t    = 64'd693598879 - ((u2 * t) >> 30);
    t    = 64'd1686629713 - ((u2 * t) >> 30);
    r    = (u * t) >> 30;
    amp  = r >> (30 - (sbits - 1));
    full = (64'd1 << (sbits - 1)) - 64'd1;
    if (amp > full) begin
      amp = full;
    end
    return amp;
  endfunction

endpackage

FILE: src/tvls_mul.sv
`timescale 1ns / 1ps
// Shared unsigned multiplier with registered product.
module tvls_mul #(
  parameter int A_BITS = 32,
  parameter int B_BITS = 17
) (
  input  logic                       clk,
  input  logic                       en,
  input  logic [A_BITS-1:0]          a,
  input  logic [B_BITS-1:0]          b,
  output logic [A_BITS+B_BITS-1:0]   p
);

  always_ff @(posedge clk) begin
    if (en) begin
      p <= (A_BITS + B_BITS)'(a) * (A_BITS + B_BITS)'(b);
    end
  end

endmodule

FILE: src/tvls_sine.sv
`timescale 1ns / 1ps
// Quarter-wave sine lookup: phase to sign and magnitude.
module tvls_sine #(
  parameter int PHASE_BITS     = 32,
  parameter int SINE_ADDR_BITS = 10,
  parameter int SAMPLE_BITS    = 16
) (
  input  logic [PHASE_BITS-1:0]  phase,
  output logic [SAMPLE_BITS-2:0] mag,
  output logic                   neg
);

  localparam int QBITS = SINE_ADDR_BITS - 2;
  localparam int QN    = 2 ** QBITS;

  logic [SINE_ADDR_BITS-1:0] addr;
  logic [1:0]                quad;
  logic [QBITS-1:0]          x;
  logic [QBITS:0]            xf;
  logic [SAMPLE_BITS-2:0]    tbl [QN+1];

  for (genvar g = 0; g <= QN; g++) begin : g_tbl
    localparam logic [63:0] AMP = tvls_pkg::quarter_sine(g, QBITS, SAMPLE_BITS);
    assign tbl[g] = AMP[SAMPLE_BITS-2:0];
  end

  assign addr = phase[PHASE_BITS-1 -: SINE_ADDR_BITS];
  assign quad = addr[SINE_ADDR_BITS-1 -: 2];
  assign x    = addr[QBITS-1:0];
  assign xf   = quad[0] ? ((QBITS+1)'(1) << QBITS) - {1'b0, x} : {1'b0, x};
  assign mag  = tbl[xf];
  assign neg  = quad[1];

endmodule

FILE: src/tvls_ctrl.sv
`timescale 1ns / 1ps
// Sequencer stepping one frame through increments, lookups, products and mixing.
module tvls_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic           enable,
  input  logic           out_free,
  output tvls_pkg::ctl_t ctl
);
  import tvls_pkg::*;

  state_t     state;
  state_t     state_next;
  logic [2:0] cnt;
  logic [2:0] cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt + 3'd1;
    case (state)
      ST_IDLE: begin
        cnt_next = '0;
        if (in_valid && enable) begin
          state_next = ST_INC;
        end
      end
      ST_INC: begin
        if (cnt == INC_LAST) begin
          state_next = ST_SINE;
          cnt_next   = '0;
        end
      end
      ST_SINE: begin
        if (cnt == SINE_LAST) begin
          state_next = ST_MUL;
          cnt_next   = '0;
        end
      end
      ST_MUL: begin
        if (cnt == MUL_LAST) begin
          state_next = ST_ACC;
          cnt_next   = '0;
        end
      end
      ST_ACC:   state_next = ST_ABS;
      ST_ABS:   state_next = ST_SCALE;
      ST_SCALE: state_next = ST_ROUND;
      ST_ROUND: begin
        cnt_next = '0;
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
        cnt_next   = '0;
      end
    endcase
  end

  always_comb begin
    ctl            = '0;
    ctl.idx        = cnt;
    ctl.in_ready   = (state == ST_IDLE);
    ctl.inc_step   = (state == ST_INC);
    ctl.inc_lo_cap = (state == ST_INC) && (cnt == INC_LAST);
    ctl.inc_hi_cap = (state == ST_SINE) && (cnt == '0);
    ctl.sine_step  = (state == ST_SINE);
    ctl.mul_step   = (state == ST_MUL);
    ctl.acc_en     = ((state == ST_MUL) && (cnt != '0)) || (state == ST_ACC);
    ctl.abs_en     = (state == ST_ABS);
    ctl.scale_en   = (state == ST_SCALE);
    ctl.round_en   = (state == ST_ROUND);
  end

endmodule

FILE: src/three_voice_lfo_sine_synth_core.sv
`timescale 1ns / 1ps
// Top level of the three-voice sine tone generator with per-voice LFO tremolo.
//
//   channel  signals                                        direction
//   in       in_valid, in_ready, end_of_buffer              request in
//   out      out_valid, out_ready, left/right_sample, last  frame out
//   cfg      cfg_we, cfg_index, cfg_data                    register write
//
// After its request is accepted a frame passes 2 increment products, 6 table lookups,
// 3 voice products and 4 mixing steps; a new request is taken only after the return
// to idle, as the single multiplier and sine table serve every step of the frame.
// Reset clears the phases and loads the register defaults (enable set).
// A request accepted while disabled is dropped. A stalled frame holds in the
// output register; the next request is taken meanwhile and waits at rounding.
module three_voice_lfo_sine_synth_core #(
  parameter int PHASE_BITS     = 32,
  parameter int SINE_ADDR_BITS = 10,
  parameter int SAMPLE_BITS    = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               end_of_buffer,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] left_sample,
  output logic signed [15:0] right_sample,
  output logic               buffer_last,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import tvls_pkg::*;

  localparam int SB   = SAMPLE_BITS;
  localparam int MA   = (2 * SB > 32) ? 2 * SB : 32;
  localparam int MB   = (SB - 1 > 17) ? SB - 1 : 17;
  localparam int PW   = MA + MB;
  localparam int AW   = 2 * SB + 1;
  localparam int SUMW = (PHASE_BITS > 34) ? PHASE_BITS : 34;
  localparam int RW   = 2 * SB + 16;
  localparam int WW   = (SB + 1 > 16) ? SB + 1 : 16;

  ctl_t ctl;

  logic        enable;
  logic [31:0] tone_step;
  logic [31:0] lfo_step;

  logic [PHASE_BITS-1:0] phase [6];
  logic [33:0]           inc1;
  logic [32:0]           inc4;
  logic [32:0]           inc5;
  logic [33:0]           inc_sel;
  logic [PHASE_BITS-1:0] phase_sel;
  logic [SUMW-1:0]       phase_sum;

  logic [SB-2:0] sine_mag;
  logic          sine_neg;
  logic [SB-2:0] s_mag [6];
  logic          s_neg [6];

  logic [MA-1:0] mul_a;
  logic [MB-1:0] mul_b;
  logic          mul_en;
  logic [PW-1:0] p;

  logic                 pneg;
  logic signed [AW-1:0] acc;
  logic signed [AW-1:0] prod_ext;
  logic [2*SB-1:0]      mag;
  logic                 sgn;
  logic                 last;

  logic [RW-1:0]        rsum;
  logic [SB:0]          rounded;
  logic signed [WW-1:0] word;
  logic                 out_free;

  tvls_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .enable   (enable),
    .out_free (out_free),
    .ctl      (ctl)
  );

  tvls_sine #(
    .PHASE_BITS     (PHASE_BITS),
    .SINE_ADDR_BITS (SINE_ADDR_BITS),
    .SAMPLE_BITS    (SAMPLE_BITS)
  ) u_sine (
    .phase (phase_sel),
    .mag   (sine_mag),
    .neg   (sine_neg)
  );

  tvls_mul #(
    .A_BITS (MA),
    .B_BITS (MB)
  ) u_mul (
    .clk (clk),
    .en  (mul_en),
    .a   (mul_a),
    .b   (mul_b),
    .p   (p)
  );

  assign in_ready = ctl.in_ready;
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable    <= 1'b1;
      tone_step <= TONE_STEP_RESET;
      lfo_step  <= LFO_STEP_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ENABLE:    enable    <= cfg_data[0];
        REG_TONE_STEP: tone_step <= cfg_data;
        REG_LFO_STEP:  lfo_step  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign phase_sel = phase[ctl.idx];

  always_comb begin
    case (ctl.idx)
      3'd0:    inc_sel = {2'b00, tone_step};
      3'd1:    inc_sel = inc1;
      3'd2:    inc_sel = {1'b0, tone_step, 1'b0};
      3'd3:    inc_sel = {2'b00, lfo_step};
      3'd4:    inc_sel = {1'b0, inc4};
      3'd5:    inc_sel = {1'b0, inc5};
      default: inc_sel = '0;
    endcase
  end

  assign phase_sum = SUMW'(phase_sel) + SUMW'(inc_sel);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) begin
        phase[i] <= '0;
      end
    end else if (ctl.sine_step) begin
      phase[ctl.idx] <= phase_sum[PHASE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.inc_step) begin
      inc1 <= {2'b00, tone_step} + {3'b000, tone_step[31:1]};
    end
    if (ctl.inc_lo_cap) begin
      inc4 <= p[48:16];
    end
    if (ctl.inc_hi_cap) begin
      inc5 <= p[48:16];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.sine_step || ctl.mul_step) begin
      for (int i = 0; i < 5; i++) begin
        s_mag[i] <= s_mag[i+1];
        s_neg[i] <= s_neg[i+1];
      end
      s_mag[5] <= sine_mag;
      s_neg[5] <= sine_neg;
    end
  end

  always_comb begin
    mul_en = ctl.inc_step || ctl.mul_step || ctl.scale_en;
    mul_a  = '0;
    mul_b  = '0;
    if (ctl.inc_step) begin
      mul_a = MA'(lfo_step);
      mul_b = (ctl.idx == '0) ? MB'(LFO1_MULT) : MB'(LFO2_MULT);
    end else if (ctl.mul_step) begin
      mul_a = MA'(s_mag[0]);
      mul_b = MB'(s_mag[3]);
    end else if (ctl.scale_en) begin
      mul_a = MA'(mag);
      mul_b = MB'(MIX_MULT);
    end
  end

  assign prod_ext = AW'($signed({1'b0, p[2*SB-3:0]}));

  always_ff @(posedge clk) begin
    if (ctl.mul_step) begin
      pneg <= s_neg[0] ^ s_neg[3];
    end
    if (ctl.sine_step) begin
      acc <= '0;
    end else if (ctl.acc_en) begin
      acc <= pneg ? acc - prod_ext : acc + prod_ext;
    end
    if (ctl.abs_en) begin
      sgn <= acc[AW-1];
      mag <= acc[AW-1] ? (2*SB)'(-acc) : acc[2*SB-1:0];
    end
  end

  assign rsum    = RW'(p[2*SB+14:0]) + (RW'(1) << (14 + SB));
  assign rounded = rsum[RW-1 -: SB+1];
  assign word    = sgn ? -$signed(WW'(rounded)) : $signed(WW'(rounded));

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      last <= end_of_buffer;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.round_en && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.round_en && out_free) begin
      left_sample  <= word[15:0];
      right_sample <= word[15:0];
      buffer_last  <= last;
    end
  end

`ifndef NO_ASSERTIONS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && enable) |=> !in_ready)
    else $error("request accepted while a frame is in progress");

  a_result_from_round: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(ctl.round_en))
    else $error("frame presented outside the rounding step");

  a_one_step: assert property (@(posedge clk) disable iff (rst)
    $onehot0({ctl.inc_step, ctl.sine_step, ctl.mul_step, ctl.acc_en && !ctl.mul_step,
              ctl.abs_en, ctl.scale_en, ctl.round_en, ctl.in_ready}))
    else $error("sequencer steps overlap");

  a_mix_bound: assert property (@(posedge clk) disable iff (rst)
    ctl.scale_en |-> (64'(mag) <= 64'd3 * ((64'd1 << (SAMPLE_BITS - 1)) - 64'd1)
                                        * ((64'd1 << (SAMPLE_BITS - 1)) - 64'd1)))
    else $error("voice sum exceeds three full-scale products");
`endif

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for the three-voice sine tone generator: directed and random requests.
module tb;
  import tvls_pkg::*;

  localparam logic [1:0] REG_NONE = 2'd3;
  localparam int SETTLE_CYCLES = 40;
  localparam logic [63:0] LFO1_GAIN = 64'd68157;
  localparam logic [63:0] LFO2_GAIN = 64'd71434;
  localparam logic [63:0] MIX_GAIN = 64'd19661;

  typedef struct packed {
    logic [15:0] left;
    logic [15:0] right;
    logic        last;
  } frame_t;

  class tone_scoreboard;
    logic [31:0] phase [6];
    logic        enabled;
    logic [31:0] tone_inc;
    logic [31:0] lfo_inc;
    frame_t      pending_frames [$];
    int          frames_seen;
    int          errors;

    function new();
      for (int v = 0; v < 6; v++) begin
        phase[v] = '0;
      end
      enabled = 1'b1;
      tone_inc = 32'd16800042;
      lfo_inc = 32'd48696;
      frames_seen = 0;
      errors = 0;
    endfunction

    function void write_reg(logic [1:0] index, logic [31:0] data);
      case (index)
        REG_ENABLE: begin
          enabled = data[0];
        end
        REG_TONE_STEP: begin
          tone_inc = data;
        end
        REG_LFO_STEP: begin
          lfo_inc = data;
        end
        default: begin
        end
      endcase
    endfunction

    function logic [63:0] taylor_coef(int k);
      case (k)
        0: return 64'd172272;
        1: return 64'd5026900;
        2: return 64'd85568169;
        3: return 64'd693598879;
        default: return 64'd1686629713;
      endcase
    endfunction

    function logic signed [15:0] wave_at(logic [31:0] ph);
      logic [9:0]  addr;
      logic [8:0]  x;
      logic [63:0] u;
      logic [63:0] u2;
      logic [63:0] poly;
      logic [63:0] amp;
      addr = ph[31:22];
      x = {1'b0, addr[7:0]};
      if (addr[8]) begin
        x = 9'd256 - x;
      end
      u = 64'(x) << 22;
      u2 = (u * u) >> 30;
      poly = taylor_coef(0);
      for (int k = 1; k < 5; k++) begin
        poly = taylor_coef(k) - ((u2 * poly) >> 30);
      end
      amp = ((u * poly) >> 30) >> 15;
      if (amp > 64'd32767) begin
        amp = 64'd32767;
      end
      return addr[9] ? -$signed(amp[15:0]) : $signed(amp[15:0]);
    endfunction

    function frame_t mix_frame(logic eob);
      longint          sum;
      longint unsigned mag;
      longint unsigned rounded;
      logic [63:0]     word;
      frame_t          f;
      sum = 0;
      for (int v = 0; v < 3; v++) begin
        sum += longint'(wave_at(phase[v])) * longint'(wave_at(phase[v + 3]));
      end
      mag = (sum < 0) ? unsigned'(-sum) : unsigned'(sum);
      rounded = (mag * MIX_GAIN + (64'd1 << 30)) >> 31;
      word = (sum < 0) ? -rounded : rounded;
      f.left = word[15:0];
      f.right = word[15:0];
      f.last = eob;
      return f;
    endfunction

    function void advance_phases();
      logic [63:0] tone;
      logic [63:0] lfo;
      logic [63:0] step [6];
      tone = 64'(tone_inc);
      lfo = 64'(lfo_inc);
      step[0] = tone;
      step[1] = tone + (tone >> 1);
      step[2] = tone << 1;
      step[3] = lfo;
      step[4] = (lfo * LFO1_GAIN) >> 16;
      step[5] = (lfo * LFO2_GAIN) >> 16;
      for (int v = 0; v < 6; v++) begin
        phase[v] = 32'(64'(phase[v]) + step[v]);
      end
    endfunction

    function void note_request(logic eob);
      if (!enabled) begin
        return;
      end
      pending_frames.insert(pending_frames.size(), mix_frame(eob));
      advance_phases();
    endfunction

    task report(string what);
      $display("ERROR frame %0d: %s", frames_seen, what);
      errors++;
    endtask

    task check_frame(logic [15:0] left, logic [15:0] right, logic last);
      frame_t want;
      frames_seen++;
      if (pending_frames.size() == 0) begin
        report($sformatf("unexpected frame %0d/%0d", $signed(left), $signed(right)));
        return;
      end
      want = pending_frames.pop_front();
      if (left !== want.left) begin
        report($sformatf("left got %0d want %0d", $signed(left), $signed(want.left)));
      end
      if (right !== want.right) begin
        report($sformatf("right got %0d want %0d", $signed(right), $signed(want.right)));
      end
      if (last !== want.last) begin
        report($sformatf("buffer_last got %b want %b", last, want.last));
      end
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        end_of_buffer = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic signed [15:0] left_sample;
  logic signed [15:0] right_sample;
  logic        buffer_last;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = REG_ENABLE;
  logic [31:0] cfg_data = '0;

  tone_scoreboard sb = new();
  int send_gap_pct = 0;
  int stall_pct = 0;
  int stall_left = 0;

  three_voice_lfo_sine_synth_core uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .end_of_buffer(end_of_buffer),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .left_sample(left_sample),
    .right_sample(right_sample),
    .buffer_last(buffer_last),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        sb.check_frame(left_sample, right_sample, buffer_last);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
        stall_left = $urandom_range(0, 10);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task send_request(input logic eob);
    int gap;
    gap = 0;
    if (send_gap_pct > 0 && $urandom_range(0, 99) < send_gap_pct) begin
      gap = $urandom_range(1, 11);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    end_of_buffer <= eob;
    do @(posedge clk); while (!in_ready);
    sb.note_request(eob);
  endtask

  task send_random(input int count);
    for (int i = 0; i < count; i++) begin
      send_request(1'($urandom_range(0, 1)));
    end
  endtask

  // hold the sender until every frame is out and the datapath has settled
  task drain();
    in_valid <= 1'b0;
    while (sb.pending_frames.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task write_reg(input logic [1:0] index, input logic [31:0] data);
    cfg_we <= 1'b1;
    cfg_index <= index;
    cfg_data <= data;
    @(posedge clk);
    sb.write_reg(index, data);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function logic [31:0] pick_step();
    case ($urandom_range(0, 5))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'($urandom_range(1, 32'h00FF_FFFF));
      default: return 32'($urandom);
    endcase
  endfunction

  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < 4; i++) begin
      send_request(1'(i));
    end
    drain();
    write_reg(REG_TONE_STEP, 32'h4000_0000);
    write_reg(REG_LFO_STEP, 32'h4000_0000);
    send_random(4);
    drain();
    write_reg(REG_TONE_STEP, 32'hFFFF_FFFF);
    write_reg(REG_LFO_STEP, 32'hFFFF_FFFF);
    send_request(1'b1);
    send_request(1'b0);
    send_random(2);
    drain();
    write_reg(REG_TONE_STEP, 32'h0000_0000);
    write_reg(REG_LFO_STEP, 32'h0000_0000);
    send_random(2);
    drain();
    write_reg(REG_ENABLE, 32'hFFFF_FFFE);
    send_random(3);
    drain();
    write_reg(REG_ENABLE, 32'hFFFF_FFFF);
    write_reg(REG_TONE_STEP, 32'h0123_4567);
    write_reg(REG_LFO_STEP, 32'h00FE_DCBA);
    write_reg(REG_NONE, 32'($urandom));
    send_random(3);

    for (int ph = 0; ph < 9; ph++) begin
      drain();
      write_reg(REG_TONE_STEP, pick_step());
      write_reg(REG_LFO_STEP, pick_step());
      if (ph % 2 == 1) begin
        write_reg(REG_NONE, 32'($urandom));
      end
      if (ph == 3) begin
        write_reg(REG_ENABLE, 32'($urandom) & 32'hFFFF_FFFE);
        send_random(4);
        drain();
        write_reg(REG_ENABLE, 32'($urandom) | 32'h0000_0001);
      end
      if (ph % 3 == 0) begin
        send_gap_pct = 0;
        stall_pct = 0;
      end else begin
        send_gap_pct = 30;
        stall_pct = 20;
      end
      send_random(22);
      if (ph == 4) begin
        drain();
      end
      send_random(23);
    end

    send_gap_pct = 0;
    stall_pct = 0;
    drain();
    write_reg(REG_TONE_STEP, 32'($urandom));
    write_reg(REG_LFO_STEP, 32'($urandom));
    send_random(30);
    drain();

    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
